/* hw/rtl/alid_pkg.sv */
// Shared types and constants for the array list block.
// No dependencies; imported by every module of the block.
package alid_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned LEN_W  = 5;

  // Operation codes carried on func_i
  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_FIND   = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // One result item
  typedef struct packed {
    status_e           status;
    logic              found;
    logic [LEN_W-1:0]  list_length;
  } res_t;

endpackage

/* hw/rtl/alid_mem.sv */
// Entry store of the list: one write port, one read port with registered data.
// Depends on alid_pkg for the data width.
module alid_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [alid_pkg::DATA_W-1:0]   wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [alid_pkg::DATA_W-1:0]   rdata_o
);
  import alid_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/alid_alu.sv */
// Shared step unit: index increment/decrement, loop bound compare, data match.
// Depends on alid_pkg for the data width.
module alid_alu #(
  parameter int unsigned CW = 5,
  parameter int unsigned PW = 5
) (
  input  logic [CW-1:0]                 idx_i,
  input  logic                          dec_i,
  input  logic [PW-1:0]                 cmp_a_i,
  input  logic [PW-1:0]                 cmp_b_i,
  input  logic [alid_pkg::DATA_W-1:0]   data_a_i,
  input  logic [alid_pkg::DATA_W-1:0]   data_b_i,
  output logic [CW-1:0]                 nxt_o,
  output logic                          lt_o,
  output logic                          eq_o
);
  import alid_pkg::*;

  // Step the index one place down or up
  assign nxt_o = dec_i ? (idx_i - CW'(1)) : (idx_i + CW'(1));

  // Loop bound and value match
  assign lt_o = (cmp_a_i < cmp_b_i);
  assign eq_o = (data_a_i == data_b_i);

endmodule

/* hw/rtl/alid_ctrl.sv */
// Sequencer of the array list: walks the entry store one entry per read/write pair.
// Depends on alid_pkg, alid_alu and the alid_mem port set.
module alid_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [alid_pkg::POS_W-1:0]    position_i,
  input  logic [alid_pkg::DATA_W-1:0]   value_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output alid_pkg::res_t                res_o,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [alid_pkg::DATA_W-1:0]   mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [alid_pkg::DATA_W-1:0]   mem_rdata_i
);
  import alid_pkg::*;

  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_PUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  func_e             op_q, op_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     count_q, count_d;
  status_e           status_q, status_d;
  logic              found_q, found_d;

  logic [PW-1:0]     pos_in;
  logic [PW-1:0]     cnt_ext;
  logic              pos_bad;
  logic              full;
  logic              pos_last;
  logic              dec;
  logic [PW-1:0]     cmp_a, cmp_b;
  logic [CW-1:0]     nxt;
  logic              lt, eq;
  logic [31:0]       cnt_wide;

  assign pos_in   = PW'(position_i);
  assign cnt_ext  = PW'(count_q);
  assign pos_bad  = (pos_in >= cnt_ext);
  assign full     = (count_q == CW'(DEPTH));
  assign pos_last = (pos_in == (cnt_ext - PW'(1)));
  assign dec      = (op_q == FUNC_INSERT);

  // Pick the loop bound for the current operation
  always_comb begin
    cmp_a = PW'(nxt);
    cmp_b = cnt_ext;
    case (op_q)
      FUNC_INSERT: begin
        cmp_a = pos_q;
        cmp_b = PW'(nxt);
      end
      FUNC_DELETE: begin
        cmp_b = cnt_ext - PW'(1);
      end
      default: begin
        cmp_a = PW'(nxt);
        cmp_b = cnt_ext;
      end
    endcase
  end

  alid_alu #(
    .CW (CW),
    .PW (PW)
  ) u_alu (
    .idx_i    (idx_q),
    .dec_i    (dec),
    .cmp_a_i  (cmp_a),
    .cmp_b_i  (cmp_b),
    .data_a_i (mem_rdata_i),
    .data_b_i (val_q),
    .nxt_o    (nxt),
    .lt_o     (lt),
    .eq_o     (eq)
  );

  // Sequence one operation
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pos_d       = pos_q;
    val_d       = val_q;
    idx_d       = idx_q;
    count_d     = count_q;
    status_d    = status_q;
    found_d     = found_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = nxt[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = func_e'(func_i);
          pos_d    = pos_in;
          val_d    = value_i;
          status_d = ST_DONE;
          found_d  = 1'b0;
          state_d  = S_DONE;
          case (func_e'(func_i))
            FUNC_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                idx_d   = count_q;
                state_d = S_PUT;
              end
            end
            FUNC_INSERT: begin
              if (pos_bad) begin
                status_d = ST_BADPOS;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                idx_d   = count_q;
                state_d = S_RD;
              end
            end
            FUNC_DELETE: begin
              if (pos_bad) begin
                status_d = ST_BADPOS;
              end else begin
                idx_d = CW'(position_i);
                if (pos_last) begin
                  count_d = count_q - CW'(1);
                end else begin
                  state_d = S_RD;
                end
              end
            end
            default: begin
              idx_d = '0;
              if (count_q != '0) begin
                state_d = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        // Find reads the current entry, the shifts read the neighbor
        if (op_q == FUNC_FIND) begin
          mem_raddr_o = idx_q[AW-1:0];
        end
        state_d = S_WR;
      end
      S_WR: begin
        case (op_q)
          FUNC_FIND: begin
            if (eq) begin
              found_d = 1'b1;
              state_d = S_DONE;
            end else begin
              idx_d   = nxt;
              state_d = lt ? S_RD : S_DONE;
            end
          end
          FUNC_INSERT: begin
            mem_we_o = 1'b1;
            idx_d    = nxt;
            state_d  = lt ? S_RD : S_PUT;
          end
          default: begin
            mem_we_o = 1'b1;
            idx_d    = nxt;
            if (lt) begin
              state_d = S_RD;
            end else begin
              count_d = count_q - CW'(1);
              state_d = S_DONE;
            end
          end
        endcase
      end
      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = val_q;
        count_d     = count_q + CW'(1);
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Operation payload and loop index
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign cnt_wide    = 32'(count_q);
  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{status: status_q, found: found_q, list_length: cnt_wide[LEN_W-1:0]};

endmodule

/* hw/rtl/array_list_insert_delete_find.sv */
// Top level of the array list: sequencer, entry store and result register.
// Depends on alid_pkg, alid_ctrl, alid_alu and alid_mem.
//
//   port group   | direction | transfer when          | payload
//   -------------+-----------+------------------------+--------------------------------
//   in           | input     | in_valid_i & in_ready_o | func_i, position_i, value_i
//   out          | output    | out_valid_o & out_ready_i | status_o, found_o, list_length_o
//
// An operation walks the entry store with one read and one write per shifted entry.
// Append writes at the end. Insert at p moves entries p..count-1 up one place, top first, then writes p.
// Delete at p moves the entries above p down one place. Find reads from entry 0 to a hit or the end.
// A result waits in the output register; the next item is taken once it is stored.
// Reset empties the list at once; entries need no clearing.
module array_list_insert_delete_find #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [alid_pkg::POS_W-1:0]    position_i,
  input  logic signed [alid_pkg::DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic                          found_o,
  output logic [alid_pkg::LEN_W-1:0]    list_length_o
);
  import alid_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              res_valid, res_ready;
  res_t              res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  logic              out_valid_q;
  res_t              out_q;

  alid_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .position_i  (position_i),
    .value_i     ($unsigned(value_i)),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  alid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Take a result when the output register is free or drains this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign found_o       = out_q.found;
  assign list_length_o = out_q.list_length;

endmodule

/* hw/rtl/alid_chk.sv */
// Port-level checker for the array list, bound to the top level.
// Depends on alid_pkg for status codes and field widths.
module alid_chk #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [alid_pkg::POS_W-1:0]    position_i,
  input  logic signed [alid_pkg::DATA_W-1:0] value_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [1:0]                    status_o,
  input  logic                          found_o,
  input  logic [alid_pkg::LEN_W-1:0]    list_length_o
);
  import alid_pkg::*;

  localparam int unsigned DEPTH_W = 32'(DEPTH);
  localparam logic [LEN_W-1:0] FULL_LEN = DEPTH_W[LEN_W-1:0];

  // Hold a stalled input transfer
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(func_i) && $stable(position_i)
      && $stable(value_i))
    else $error("input changed while stalled");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(found_o)
      && $stable(list_length_o))
    else $error("result changed while stalled");

  // Only the three defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_DONE || status_o == ST_BADPOS || status_o == ST_FULL))
    else $error("undefined status code");

  // A hit is only reported for a completed operation
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_DONE)
    else $error("found flag with error status");

  // A full report carries the capacity as length
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> list_length_o == FULL_LEN)
    else $error("full status with wrong length");

endmodule

bind array_list_insert_delete_find alid_chk #(.DEPTH(DEPTH)) u_alid_chk (.*);
